// ===== design/nbg_pkg.sv =====
package nbg_pkg;

  localparam int WORD = 128;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [1:0] CFG_GRAVITY  = 2'd0;
  localparam logic [1:0] CFG_TIMESTEP = 2'd1;
  localparam logic [1:0] CFG_ACTIVE   = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [3:0]        body_index;
    logic [31:0]       load_mass;
    logic signed [47:0] load_pos_x;
    logic signed [47:0] load_pos_y;
    logic signed [47:0] load_pos_z;
    logic signed [47:0] load_vel_x;
    logic signed [47:0] load_vel_y;
    logic signed [47:0] load_vel_z;
  } cmd_t;

  typedef struct packed {
    logic [3:0]        result_index;
    logic signed [47:0] new_pos_x;
    logic signed [47:0] new_pos_y;
    logic signed [47:0] new_pos_z;
    logic signed [47:0] new_vel_x;
    logic signed [47:0] new_vel_y;
    logic signed [47:0] new_vel_z;
    logic              coincident_flag;
    logic              saturated_flag;
  } res_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
    logic [7:0] steps;
  } alu_req_t;

endpackage

// ===== design/nbg_alu.sv =====
module nbg_alu (
  input  logic                     clk,
  input  logic                     rst,
  input  nbg_pkg::alu_req_t        req,
  input  logic [nbg_pkg::WORD-1:0] opa,
  input  logic [nbg_pkg::WORD-1:0] opb,
  output logic                     done,
  output logic [nbg_pkg::WORD-1:0] result
);

  logic [127:0] acc;
  logic [127:0] sreg;
  logic [127:0] breg;
  logic [7:0]   cnt;
  logic         busy;
  logic [1:0]   op;

  logic [127:0] rem_div;
  logic [127:0] rem_sq;
  logic [127:0] trial;
  logic [127:0] sub_x;
  logic [127:0] sub_y;
  logic [128:0] diff;
  logic         ge;
  logic [127:0] sum;

  // multiply: shift-add, multiplier LSB first
  // divide: restoring, dividend left-aligned in sreg
  // root: two radicand bits per step, root builds in breg
  always_comb begin
    rem_div = {acc[126:0], sreg[127]};
    rem_sq  = {acc[125:0], sreg[127:126]};
    trial   = {breg[125:0], 2'b01};
    sub_x   = (op == nbg_pkg::OP_SQRT) ? rem_sq : rem_div;
    sub_y   = (op == nbg_pkg::OP_SQRT) ? trial : breg;
    diff    = {1'b0, sub_x} - {1'b0, sub_y};
    ge      = ~diff[128];
    sum     = acc + (sreg[0] ? breg : '0);
    case (op)
      nbg_pkg::OP_MUL:  result = acc;
      nbg_pkg::OP_DIV:  result = sreg;
      nbg_pkg::OP_SQRT: result = breg;
      default:          result = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      acc <= '0;
      case (req.op)
        nbg_pkg::OP_MUL: begin
          breg <= opa;
          sreg <= opb;
        end
        nbg_pkg::OP_DIV: begin
          sreg <= opa;
          breg <= opb;
        end
        default: begin
          sreg <= opa;
          breg <= '0;
        end
      endcase
    end else if (busy) begin
      case (op)
        nbg_pkg::OP_MUL: begin
          acc  <= sum;
          breg <= {breg[126:0], 1'b0};
          sreg <= {1'b0, sreg[127:1]};
        end
        nbg_pkg::OP_DIV: begin
          acc  <= ge ? diff[127:0] : sub_x;
          sreg <= {sreg[126:0], ge};
        end
        nbg_pkg::OP_SQRT: begin
          acc  <= ge ? diff[127:0] : sub_x;
          breg <= {breg[126:0], ge};
          sreg <= {sreg[125:0], 2'b00};
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

endmodule

// ===== design/nbody_gravity_step.sv =====
// channel  | handshake                  | payload
// cmd      | cmd_valid / cmd_stall      | cmd (load or advance item)
// res      | res_valid / res_stall      | res (stored entry after the item)
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Advance items run every product, quotient and root in turn through
// the one shared bit-serial unit (multiply, restoring divide, root).
// Synchronous reset clears the sequencer and the result slot and sets the
// registers to their defaults; the body tables stay undefined until loaded.
// cmd_stall is high while an item is in work; a stalled result waits in the
// output register and holds the sequencer at its last step.
module nbody_gravity_step #(
  parameter int BODY_SLOTS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  nbg_pkg::cmd_t  cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output nbg_pkg::res_t  res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_data
);

  localparam int SW   = $clog2(BODY_SLOTS);
  localparam int NW   = $clog2(BODY_SLOTS + 1);
  localparam int AW   = $clog2(3 * BODY_SLOTS);
  localparam int ACCW = 48 + $clog2(BODY_SLOTS);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_LOAD     = 5'd1;
  localparam logic [4:0] S_OWN_RD   = 5'd2;
  localparam logic [4:0] S_OWN_CAP  = 5'd3;
  localparam logic [4:0] S_DT2      = 5'd4;
  localparam logic [4:0] S_DT2_W    = 5'd5;
  localparam logic [4:0] S_PAIR     = 5'd6;
  localparam logic [4:0] S_J_RD     = 5'd7;
  localparam logic [4:0] S_J_CAP    = 5'd8;
  localparam logic [4:0] S_SQ_W     = 5'd9;
  localparam logic [4:0] S_SQRT_W   = 5'd10;
  localparam logic [4:0] S_R2_W     = 5'd11;
  localparam logic [4:0] S_GM_W     = 5'd12;
  localparam logic [4:0] S_W_GO     = 5'd13;
  localparam logic [4:0] S_W_W      = 5'd14;
  localparam logic [4:0] S_P_W      = 5'd15;
  localparam logic [4:0] S_T_W      = 5'd16;
  localparam logic [4:0] S_F_RD     = 5'd17;
  localparam logic [4:0] S_F_CAP    = 5'd18;
  localparam logic [4:0] S_F_GO     = 5'd19;
  localparam logic [4:0] S_DV_W     = 5'd20;
  localparam logic [4:0] S_DP_W     = 5'd21;
  localparam logic [4:0] S_DA_W     = 5'd22;
  localparam logic [4:0] S_F_WR     = 5'd23;
  localparam logic [4:0] S_DONE     = 5'd24;

  function automatic logic [SW-1:0] slot_of(input logic [3:0] idx);
    logic [3:0] v;
    v = idx;
    for (int i = 0; i < 8; i++) begin
      if (32'(v) >= BODY_SLOTS) v = v - 4'(BODY_SLOTS);
    end
    return SW'(v);
  endfunction

  // {clamped, value}: magnitude limited to the 48-bit range of its sign
  function automatic logic [48:0] sat_mag(input logic neg, input logic [127:0] mag);
    logic [127:0] lim;
    logic [47:0]  v;
    logic         s;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    s   = mag > lim;
    v   = s ? lim[47:0] : mag[47:0];
    if (neg) v = -v;
    return {s, v};
  endfunction

  function automatic logic [48:0] clamp50(input logic [49:0] x);
    logic fits;
    fits = (x[49:47] == 3'b000) || (x[49:47] == 3'b111);
    if (fits) return {1'b0, x[47:0]};
    return x[49] ? {1'b1, 48'h8000_0000_0000} : {1'b1, 48'h7FFF_FFFF_FFFF};
  endfunction

  logic [4:0]  state;
  logic [31:0] gravity;
  logic [31:0] tstep;
  logic [4:0]  active;

  nbg_pkg::cmd_t cmd_r;
  logic [SW-1:0] me;
  logic [NW-1:0] jc;
  logic [NW-1:0] n_act;
  logic [1:0]    k;
  logic          coin;
  logic          sat;

  logic signed [47:0]     pme  [3];
  logic [48:0]            dm   [3];
  logic                   dpos [3];
  logic signed [ACCW-1:0] acc3 [3];
  logic signed [47:0]     newp [3];
  logic signed [47:0]     newv [3];

  logic [97:0]  s;
  logic [49:0]  r;
  logic [98:0]  r2;
  logic [63:0]  gm;
  logic [63:0]  dt2;
  logic [47:0]  a_val;
  logic [47:0]  p0;
  logic [47:0]  v0;
  logic [47:0]  dv;
  logic [47:0]  dp;
  logic [47:0]  da;

  logic [47:0] pos_mem  [3*BODY_SLOTS];
  logic [47:0] vel_mem  [3*BODY_SLOTS];
  logic [31:0] mass_mem [BODY_SLOTS];
  logic [47:0] pos_rd;
  logic [47:0] vel_rd;
  logic [31:0] mass_rd;

  nbg_pkg::alu_req_t alu_req;
  logic [127:0]      alu_a;
  logic [127:0]      alu_b;
  logic              alu_done;
  logic [127:0]      alu_res;

  logic [SW-1:0] jc_slot;
  logic [SW-1:0] slot_sel;
  logic [AW-1:0] mem_addr;
  logic          mem_we;
  logic [47:0]   pos_wdata;
  logic [47:0]   vel_wdata;
  logic [48:0]   dsum;
  logic [48:0]   dmag_c;
  logic [97:0]   s_next;
  logic [48:0]   term;
  logic [ACCW-1:0] acc_k;
  logic          acc_fits;
  logic [47:0]   a_clamp;
  logic [47:0]   amag;
  logic [47:0]   vmag;
  logic [48:0]   dv_c;
  logic [48:0]   dp_c;
  logic [48:0]   da_c;
  logic [48:0]   vnew;
  logic [48:0]   pnew;
  logic [47:0]   ld_pos;
  logic [47:0]   ld_vel;

  assign cmd_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign jc_slot   = jc[SW-1:0];

  nbg_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  always_comb begin
    slot_sel = (state == S_J_RD) ? jc_slot : me;
    mem_addr = (AW'(slot_sel) << 1) + AW'(slot_sel) + AW'(k);
    mem_we   = (state == S_LOAD) || (state == S_F_WR);

    dsum   = {pme[k][47], pme[k]} - {pos_rd[47], pos_rd};
    dmag_c = dsum[48] ? -dsum : dsum;
    s_next = s + alu_res[97:0];
    term   = sat_mag(dpos[k], alu_res);

    acc_k    = acc3[k];
    acc_fits = (&acc_k[ACCW-1:47]) || (~|acc_k[ACCW-1:47]);
    a_clamp  = acc_fits ? acc_k[47:0]
             : (acc_k[ACCW-1] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF);
    amag = a_val[47] ? -a_val : a_val;
    vmag = v0[47] ? -v0 : v0;
    dv_c = sat_mag(a_val[47], {16'b0, alu_res[127:16]});
    dp_c = sat_mag(v0[47], {16'b0, alu_res[127:16]});
    da_c = sat_mag(a_val[47], {33'b0, alu_res[127:33]});
    vnew = clamp50({{2{v0[47]}}, v0} + {{2{dv[47]}}, dv});
    pnew = clamp50({{2{p0[47]}}, p0} + {{2{dp[47]}}, dp} + {{2{da[47]}}, da});

    case (k)
      2'd0: begin
        ld_pos = cmd_r.load_pos_x;
        ld_vel = cmd_r.load_vel_x;
      end
      2'd1: begin
        ld_pos = cmd_r.load_pos_y;
        ld_vel = cmd_r.load_vel_y;
      end
      default: begin
        ld_pos = cmd_r.load_pos_z;
        ld_vel = cmd_r.load_vel_z;
      end
    endcase
    pos_wdata = (state == S_LOAD) ? ld_pos : pnew[47:0];
    vel_wdata = (state == S_LOAD) ? ld_vel : vnew[47:0];

    alu_req = '0;
    alu_a   = '0;
    alu_b   = '0;
    case (state)
      S_DT2: begin
        alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd32};
        alu_a   = 128'(tstep);
        alu_b   = 128'(tstep);
      end
      S_J_CAP: begin
        alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd49};
        alu_a   = 128'(dmag_c);
        alu_b   = 128'(dmag_c);
      end
      S_SQ_W: begin
        if (alu_done && k == 2'd2 && s_next != '0) begin
          alu_req = '{1'b1, nbg_pkg::OP_SQRT, 8'd50};
          alu_a   = {2'b00, s_next, 28'b0};
        end
      end
      S_SQRT_W: begin
        if (alu_done) begin
          alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd50};
          alu_a   = 128'(alu_res[49:0]);
          alu_b   = 128'(alu_res[49:0]);
        end
      end
      S_R2_W: begin
        if (alu_done) begin
          alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd32};
          alu_a   = 128'(gravity);
          alu_b   = 128'(mass_rd);
        end
      end
      S_W_GO: begin
        alu_req = '{1'b1, nbg_pkg::OP_DIV, 8'd89};
        alu_a   = {dm[k], 79'b0};
        alu_b   = 128'(r);
      end
      S_W_W: begin
        if (alu_done) begin
          alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd41};
          alu_a   = 128'(gm);
          alu_b   = 128'(alu_res[40:0]);
        end
      end
      S_P_W: begin
        // floor(floor(x/r)/r) == floor(x/r^2)
        if (alu_done) begin
          alu_req = '{1'b1, nbg_pkg::OP_DIV, 8'd105};
          alu_a   = {alu_res[104:0], 23'b0};
          alu_b   = 128'(r2);
        end
      end
      S_F_GO: begin
        alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd32};
        alu_a   = 128'(amag);
        alu_b   = 128'(tstep);
      end
      S_DV_W: begin
        if (alu_done) begin
          alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd32};
          alu_a   = 128'(vmag);
          alu_b   = 128'(tstep);
        end
      end
      S_DP_W: begin
        if (alu_done) begin
          alu_req = '{1'b1, nbg_pkg::OP_MUL, 8'd64};
          alu_a   = 128'(amag);
          alu_b   = 128'(dt2);
        end
      end
      default: begin
        alu_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pos_mem[mem_addr] <= pos_wdata;
      vel_mem[mem_addr] <= vel_wdata;
    end
    if (state == S_LOAD && k == 2'd0) begin
      mass_mem[me] <= cmd_r.load_mass;
    end
    pos_rd  <= pos_mem[mem_addr];
    vel_rd  <= vel_mem[mem_addr];
    mass_rd <= mass_mem[jc_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= 32'd65536;
      tstep   <= 32'd65536;
      active  <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nbg_pkg::CFG_GRAVITY:  gravity <= cfg_data;
        nbg_pkg::CFG_TIMESTEP: tstep   <= cfg_data;
        nbg_pkg::CFG_ACTIVE:   active  <= cfg_data[4:0];
        default:               active  <= active;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= (cmd.command == nbg_pkg::CMD_ADVANCE) ? S_OWN_RD : S_LOAD;
          end
        end
        S_LOAD:    if (k == 2'd2) state <= S_DONE;
        S_OWN_RD:  state <= S_OWN_CAP;
        S_OWN_CAP: state <= (k == 2'd2) ? S_DT2 : S_OWN_RD;
        S_DT2:     state <= S_DT2_W;
        S_DT2_W:   if (alu_done) state <= S_PAIR;
        S_PAIR: begin
          if (jc == n_act) state <= S_F_RD;
          else if (jc_slot != me) state <= S_J_RD;
        end
        S_J_RD:  state <= S_J_CAP;
        S_J_CAP: state <= S_SQ_W;
        S_SQ_W: begin
          if (alu_done) begin
            if (k != 2'd2) state <= S_J_RD;
            else if (s_next == '0) state <= S_PAIR;
            else state <= S_SQRT_W;
          end
        end
        S_SQRT_W: if (alu_done) state <= S_R2_W;
        S_R2_W:   if (alu_done) state <= S_GM_W;
        S_GM_W:   if (alu_done) state <= S_W_GO;
        S_W_GO:   state <= S_W_W;
        S_W_W:    if (alu_done) state <= S_P_W;
        S_P_W:    if (alu_done) state <= S_T_W;
        S_T_W:    if (alu_done) state <= (k == 2'd2) ? S_PAIR : S_W_GO;
        S_F_RD:   state <= S_F_CAP;
        S_F_CAP:  state <= S_F_GO;
        S_F_GO:   state <= S_DV_W;
        S_DV_W:   if (alu_done) state <= S_DP_W;
        S_DP_W:   if (alu_done) state <= S_DA_W;
        S_DA_W:   if (alu_done) state <= S_F_WR;
        S_F_WR:   state <= (k == 2'd2) ? S_DONE : S_F_RD;
        S_DONE: begin
          // hold until the result slot is free
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd_r <= cmd;
        me    <= slot_of(cmd.body_index);
        jc    <= '0;
        k     <= '0;
        coin  <= 1'b0;
        sat   <= 1'b0;
        n_act <= (32'(active) > BODY_SLOTS) ? NW'(BODY_SLOTS) : NW'(active);
        for (int i = 0; i < 3; i++) acc3[i] <= '0;
      end
      S_LOAD: begin
        newp[k] <= ld_pos;
        newv[k] <= ld_vel;
        k       <= k + 2'd1;
      end
      S_OWN_CAP: begin
        pme[k] <= pos_rd;
        k      <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      S_DT2_W: if (alu_done) dt2 <= alu_res[63:0];
      S_PAIR: begin
        k <= '0;
        s <= '0;
        if (jc != n_act && jc_slot == me) jc <= jc + NW'(1);
      end
      S_J_CAP: begin
        dm[k]   <= dmag_c;
        dpos[k] <= ~dsum[48] && (dsum != '0);
      end
      S_SQ_W: begin
        if (alu_done) begin
          s <= s_next;
          if (k != 2'd2) begin
            k <= k + 2'd1;
          end else if (s_next == '0) begin
            // skip the coincident pair
            coin <= 1'b1;
            jc   <= jc + NW'(1);
          end
        end
      end
      S_SQRT_W: if (alu_done) r <= alu_res[49:0];
      S_R2_W:   if (alu_done) r2 <= alu_res[98:0];
      S_GM_W: begin
        if (alu_done) begin
          gm <= alu_res[63:0];
          k  <= '0;
        end
      end
      S_T_W: begin
        if (alu_done) begin
          acc3[k] <= acc3[k] + {{(ACCW-48){term[47]}}, term[47:0]};
          if (term[48]) sat <= 1'b1;
          if (k == 2'd2) jc <= jc + NW'(1);
          else k <= k + 2'd1;
        end
      end
      S_F_CAP: begin
        p0    <= pos_rd;
        v0    <= vel_rd;
        a_val <= a_clamp;
        if (!acc_fits) sat <= 1'b1;
      end
      S_DV_W: begin
        if (alu_done) begin
          dv <= dv_c[47:0];
          if (dv_c[48]) sat <= 1'b1;
        end
      end
      S_DP_W: begin
        if (alu_done) begin
          dp <= dp_c[47:0];
          if (dp_c[48]) sat <= 1'b1;
        end
      end
      S_DA_W: begin
        if (alu_done) begin
          da <= da_c[47:0];
          if (da_c[48]) sat <= 1'b1;
        end
      end
      S_F_WR: begin
        newp[k] <= pnew[47:0];
        newv[k] <= vnew[47:0];
        if (pnew[48] || vnew[48]) sat <= 1'b1;
        k <= k + 2'd1;
      end
      S_DONE: begin
        if (!res_valid || !res_stall) begin
          res.result_index    <= 4'(me);
          res.new_pos_x       <= newp[0];
          res.new_pos_y       <= newp[1];
          res.new_pos_z       <= newp[2];
          res.new_vel_x       <= newv[0];
          res.new_vel_y       <= newv[1];
          res.new_vel_z       <= newv[2];
          res.coincident_flag <= coin;
          res.saturated_flag  <= sat;
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

endmodule

// ===== bench/nbody_gravity_step_test.sv =====
`timescale 1ns / 100ps

module nbody_gravity_step_test;

  localparam int SLOTS = 16;
  localparam int IDLE_LIMIT = 60000;
  localparam int HOLD_CYCLES = 2000;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic signed [63:0] POS_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] POS_MIN = -64'sh8000_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  nbg_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  nbg_pkg::res_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  nbody_gravity_step #(.BODY_SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // body table and registers as the block should hold them
  logic signed [47:0] pos_tab [SLOTS][3];
  logic signed [47:0] vel_tab [SLOTS][3];
  logic [31:0] mass_tab [SLOTS];
  logic [31:0] grav_reg = 32'h1_0000;
  logic [31:0] step_reg = 32'h1_0000;
  logic [4:0] active_reg = 5'd16;
  logic clamp_hit;

  nbg_pkg::res_t pending_results [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  int hold_left = 0;

  function automatic logic signed [63:0] clamp_mag(logic neg, logic [127:0] mg);
    logic [63:0] lim;
    lim = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    if (mg > {64'd0, lim}) begin
      mg = {64'd0, lim};
      clamp_hit = 1'b1;
    end
    return neg ? -$signed(mg[63:0]) : $signed(mg[63:0]);
  endfunction

  function automatic logic signed [63:0] clamp48(logic signed [63:0] x);
    if (x > POS_MAX) begin
      clamp_hit = 1'b1;
      return POS_MAX;
    end
    if (x < POS_MIN) begin
      clamp_hit = 1'b1;
      return POS_MIN;
    end
    return x;
  endfunction

  function automatic logic [63:0] magnitude(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic signed [63:0] scale_by(logic signed [63:0] x, logic [63:0] f,
                                                   int sh);
    logic [127:0] prod;
    prod = ({64'd0, magnitude(x)} * {64'd0, f}) >> sh;
    return clamp_mag(x < 0, prod);
  endfunction

  function automatic logic [63:0] root_floor(logic [127:0] s);
    logic [127:0] c;
    logic [63:0] acc;
    acc = 0;
    for (int b = 49; b >= 0; b--) begin
      c = {64'd0, acc | (64'd1 << b)};
      if (c * c <= s) acc = c[63:0];
    end
    return acc;
  endfunction

  // apply one command to the table and return the entry it leaves behind
  function automatic nbg_pkg::res_t apply_command(nbg_pkg::cmd_t c);
    int me, n;
    logic signed [63:0] acc [3];
    logic signed [63:0] delta [3];
    logic [63:0] dmag [3];
    logic [127:0] s, q, t;
    logic [63:0] r, gm, w, dt2;
    logic signed [63:0] a, v, dv, dp, da;
    logic coin;
    nbg_pkg::res_t o;
    me = c.body_index;
    coin = 1'b0;
    clamp_hit = 1'b0;
    if (c.command == nbg_pkg::CMD_LOAD) begin
      mass_tab[me] = c.load_mass;
      pos_tab[me][0] = c.load_pos_x;
      pos_tab[me][1] = c.load_pos_y;
      pos_tab[me][2] = c.load_pos_z;
      vel_tab[me][0] = c.load_vel_x;
      vel_tab[me][1] = c.load_vel_y;
      vel_tab[me][2] = c.load_vel_z;
    end else begin
      n = active_reg > SLOTS ? SLOTS : active_reg;
      for (int k = 0; k < 3; k++) acc[k] = 0;
      for (int j = 0; j < n; j++) begin
        if (j == me) continue;
        s = 0;
        for (int k = 0; k < 3; k++) begin
          delta[k] = 64'(pos_tab[me][k]) - 64'(pos_tab[j][k]);
          dmag[k] = magnitude(delta[k]);
          s = s + {64'd0, dmag[k]} * {64'd0, dmag[k]};
        end
        if (s == 0) begin
          coin = 1'b1;
          continue;
        end
        r = root_floor(s);
        gm = {32'd0, grav_reg} * {32'd0, mass_tab[j]};
        for (int k = 0; k < 3; k++) begin
          q = ({64'd0, dmag[k]} << 40) / {64'd0, r};
          w = q[63:0];
          q = ({64'd0, gm} * {64'd0, w}) / {64'd0, r};
          t = q / {64'd0, r};
          acc[k] = acc[k] + clamp_mag(delta[k] > 0, t);
        end
      end
      dt2 = {32'd0, step_reg} * {32'd0, step_reg};
      for (int k = 0; k < 3; k++) begin
        a = clamp48(acc[k]);
        v = 64'(vel_tab[me][k]);
        dv = scale_by(a, {32'd0, step_reg}, 16);
        dp = scale_by(v, {32'd0, step_reg}, 16);
        da = scale_by(a, dt2, 33);
        vel_tab[me][k] = clamp48(v + dv);
        pos_tab[me][k] = clamp48(64'(pos_tab[me][k]) + dp + da);
      end
    end
    o.result_index = me[3:0];
    o.new_pos_x = pos_tab[me][0];
    o.new_pos_y = pos_tab[me][1];
    o.new_pos_z = pos_tab[me][2];
    o.new_vel_x = vel_tab[me][0];
    o.new_vel_y = vel_tab[me][1];
    o.new_vel_z = vel_tab[me][2];
    o.coincident_flag = coin;
    o.saturated_flag = c.command == nbg_pkg::CMD_LOAD ? 1'b0 : clamp_hit;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    nbg_pkg::res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing pending", 64'(res.result_index), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (res.result_index !== want.result_index)
          report_mismatch("result_index", 64'(res.result_index), 64'(want.result_index));
        if (res.new_pos_x !== want.new_pos_x)
          report_mismatch("new_pos_x", 64'(res.new_pos_x), 64'(want.new_pos_x));
        if (res.new_pos_y !== want.new_pos_y)
          report_mismatch("new_pos_y", 64'(res.new_pos_y), 64'(want.new_pos_y));
        if (res.new_pos_z !== want.new_pos_z)
          report_mismatch("new_pos_z", 64'(res.new_pos_z), 64'(want.new_pos_z));
        if (res.new_vel_x !== want.new_vel_x)
          report_mismatch("new_vel_x", 64'(res.new_vel_x), 64'(want.new_vel_x));
        if (res.new_vel_y !== want.new_vel_y)
          report_mismatch("new_vel_y", 64'(res.new_vel_y), 64'(want.new_vel_y));
        if (res.new_vel_z !== want.new_vel_z)
          report_mismatch("new_vel_z", 64'(res.new_vel_z), 64'(want.new_vel_z));
        if (res.coincident_flag !== want.coincident_flag)
          report_mismatch("coincident_flag", 64'(res.coincident_flag),
                          64'(want.coincident_flag));
        if (res.saturated_flag !== want.saturated_flag)
          report_mismatch("saturated_flag", 64'(res.saturated_flag),
                          64'(want.saturated_flag));
      end
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    int quiet;
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_item(nbg_pkg::cmd_t c);
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!(cmd_valid && !cmd_stall));
    pending_results = {pending_results, apply_command(c)};
    if ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain_results;
    // drop valid so the accepted item is not offered again
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      nbg_pkg::CFG_GRAVITY: grav_reg = val;
      nbg_pkg::CFG_TIMESTEP: step_reg = val;
      nbg_pkg::CFG_ACTIVE: active_reg = val[4:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [47:0] rand_coord();
    logic [47:0] x;
    x = 48'({$urandom, $urandom});
    if ($urandom_range(1)) x = {{18{x[29]}}, x[29:0]};
    return x;
  endfunction

  function automatic nbg_pkg::cmd_t load_item(int idx, logic [31:0] mass,
                                              logic signed [47:0] px,
                                              logic signed [47:0] py,
                                              logic signed [47:0] pz,
                                              logic signed [47:0] vx,
                                              logic signed [47:0] vy,
                                              logic signed [47:0] vz);
    nbg_pkg::cmd_t c;
    c.command = nbg_pkg::CMD_LOAD;
    c.body_index = idx[3:0];
    c.load_mass = mass;
    c.load_pos_x = px;
    c.load_pos_y = py;
    c.load_pos_z = pz;
    c.load_vel_x = vx;
    c.load_vel_y = vy;
    c.load_vel_z = vz;
    return c;
  endfunction

  function automatic nbg_pkg::cmd_t advance_item(int idx);
    nbg_pkg::cmd_t c;
    c = '0;
    c.command = nbg_pkg::CMD_ADVANCE;
    c.body_index = idx[3:0];
    return c;
  endfunction

  // every entry gets written before any advance reads the table
  task automatic test_table_load;
    send_item(load_item(0, 32'h1_0000, 48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF,
                        48'sh7FFF_FFFF_FFFF, -48'sh8000_0000_0000, 0, 48'sh7FFF_FFFF_FFFF));
    send_item(load_item(1, 32'hFFFF_FFFF, -48'sh8000_0000_0000, -48'sh8000_0000_0000,
                        -48'sh8000_0000_0000, 48'sh7FFF_FFFF_FFFF, -1, 0));
    for (int i = 2; i < SLOTS; i++)
      send_item(load_item(i, i == 15 ? 32'd0 : 32'h1_0000 * i,
                          48'sh100_0000 * (i == 3 ? 2 : i),
                          48'sh80_0000 * (i == 3 ? 2 : i), 0,
                          48'sh1_0000 * i, -48'sh4000 * i, 48'sh10 * i));
    drain_results();
  endtask

  task automatic test_special_cases;
    // entry 3 sits on entry 2
    send_item(advance_item(2));
    drain_results();
    write_register(nbg_pkg::CFG_ACTIVE, 32'd2);
    send_item(advance_item(9));
    drain_results();
    write_register(nbg_pkg::CFG_ACTIVE, 32'd0);
    send_item(advance_item(5));
    drain_results();
    write_register(nbg_pkg::CFG_ACTIVE, 32'd31);
    send_item(advance_item(7));
    drain_results();
    // heavy close pair at full gravity and step: drive the clamps
    write_register(nbg_pkg::CFG_GRAVITY, 32'hFFFF_FFFF);
    write_register(nbg_pkg::CFG_TIMESTEP, 32'hFFFF_FFFF);
    write_register(nbg_pkg::CFG_ACTIVE, 32'd6);
    send_item(load_item(4, 32'hFFFF_FFFF, 48'sh500_0001, 48'sh280_0000, 0, 0, 0, 0));
    send_item(advance_item(5));
    drain_results();
    write_register(nbg_pkg::CFG_GRAVITY, 32'd0);
    write_register(nbg_pkg::CFG_TIMESTEP, 32'd0);
    write_register(CFG_UNUSED, 32'hFFFF_FFFF);
    send_item(advance_item(4));
    drain_results();
  endtask

  task automatic test_random_phase(int count, int idle_pct, int stall_pct);
    nbg_pkg::cmd_t c;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_register(nbg_pkg::CFG_GRAVITY,
                   $urandom_range(1) ? $urandom : $urandom_range(0, 32'h4_0000));
    write_register(nbg_pkg::CFG_TIMESTEP, $urandom_range(3) == 0 ? $urandom :
                                          $urandom_range(0, 32'h2_0000));
    write_register(nbg_pkg::CFG_ACTIVE, $urandom_range(1, 3));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 30) begin
        c = advance_item($urandom_range(SLOTS - 1));
      end else begin
        c = load_item($urandom_range(SLOTS - 1), $urandom, rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      send_item(c);
    end
    drain_results();
  endtask

  // hold results off while items keep coming, so the block backs up
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1;
    for (int i = 0; i < 4; i++)
      send_item(load_item($urandom_range(SLOTS - 1), $urandom, rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(), rand_coord(), rand_coord()));
    send_item(advance_item($urandom_range(SLOTS - 1)));
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_special_cases();
    test_random_phase(230, 0, 0);
    test_random_phase(230, 59, 0);
    test_backpressure();
    test_random_phase(230, 0, 59);
    test_random_phase(230, 36, 36);
    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/nbg_pkg.sv
design/nbg_alu.sv
design/nbody_gravity_step.sv
bench/nbody_gravity_step_test.sv
